@@ hdl/ffha_pkg.sv @@
package ffha_pkg;

	// Heap geometry.
	localparam int HEAP_BYTES     = 65536;
	localparam int GRANULE_BYTES  = 16;
	localparam int FREE_HDR_BYTES = 16;
	localparam int USED_HDR_BYTES = 16;
	localparam int MIN_FREE_BYTES = 32;
	localparam int NGRAN          = HEAP_BYTES / GRANULE_BYTES;
	localparam int GRAN_AW        = $clog2(NGRAN);
	localparam int SPAN_W         = GRAN_AW + 1;
	localparam int TAG_W          = 16;

	// Tag kinds, held in the top two bits of a tag.
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_FREE = 2'd1;
	localparam logic [1:0] KIND_USED = 2'd2;

	// Operation and status codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_MEM   = 2'd1;
	localparam logic [1:0] ST_BAD_ADDR = 2'd2;

	typedef struct packed {
		logic        op;
		logic [15:0] request_bytes;
		logic [15:0] block_addr;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] data_addr;
		logic [16:0] free_bytes;
		logic [16:0] used_bytes;
		logic [12:0] free_blocks;
		logic [12:0] used_blocks;
		logic [16:0] peak_bytes;
		logic [12:0] peak_blocks;
	} result_t;

	typedef struct packed {
		logic [16:0] free_total;
		logic [16:0] used_total;
		logic [12:0] free_count;
		logic [12:0] used_count;
	} stats_t;

	typedef struct packed {
		logic   we;
		stats_t val;
	} stats_upd_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_CHK, S_ARD, S_AEV, S_AW2,
		S_FRD, S_FEV, S_FTGT, S_FNXT, S_FCOMMIT, S_DONE
	} state_t;

endpackage

@@ hdl/ffha_ram.sv @@
module ffha_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/ffha_stats.sv @@
module ffha_stats import ffha_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  stats_upd_t upd,
	output stats_t     cur,
	output logic [16:0] peak_bytes,
	output logic [12:0] peak_blocks
);

	stats_t      stats_q;
	logic [16:0] peak_bytes_q;
	logic [12:0] peak_blocks_q;

	// Running totals and high-water marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_q.free_total <= 17'(HEAP_BYTES - FREE_HDR_BYTES);
			stats_q.used_total <= '0;
			stats_q.free_count <= 13'd1;
			stats_q.used_count <= '0;
			peak_bytes_q       <= '0;
			peak_blocks_q      <= '0;
		end else if (upd.we) begin
			stats_q <= upd.val;
			if (upd.val.used_total > peak_bytes_q) begin
				peak_bytes_q <= upd.val.used_total;
			end
			if (upd.val.used_count > peak_blocks_q) begin
				peak_blocks_q <= upd.val.used_count;
			end
		end
	end

	assign cur         = stats_q;
	assign peak_bytes  = peak_bytes_q;
	assign peak_blocks = peak_blocks_q;

endmodule

@@ hdl/ffha_ctrl.sv @@
module ffha_ctrl import ffha_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  cmd_t               cmd,
	output logic               busy,
	output logic               fin,
	output logic [1:0]         fin_status,
	output logic [15:0]        fin_addr,
	input  stats_t             st,
	output stats_upd_t         upd,
	output logic               ram_we,
	output logic [GRAN_AW-1:0] ram_waddr,
	output logic [TAG_W-1:0]   ram_wdata,
	output logic [GRAN_AW-1:0] ram_raddr,
	input  logic [TAG_W-1:0]   ram_rdata
);

	state_t state_q, state_d;

	logic              op_q;
	logic [16:0]       adj_q;
	logic [17:0]       need_q;
	logic [SPAN_W-1:0] g_q, tgt_q, prev_q, prev_span_q, span_q, uspan_q, nspan_q;
	logic              has_prev_q, prev_free_q, nfree_q, split_q;
	logic [1:0]        status_q;
	logic [15:0]       addr_q;

	// Fields of the tag just read.
	logic [1:0]        t_kind;
	logic [SPAN_W-1:0] t_span;
	logic [16:0]       t_bytes;
	logic              fit;
	logic [16:0]       rem;
	logic              split;
	logic [SPAN_W-1:0] need_span;
	logic [SPAN_W-1:0] nxt;
	logic              bad_free;
	logic [16:0]       cmd_adj;
	logic [16:0]       tspan_bytes;

	assign t_kind    = ram_rdata[15:14];
	assign t_span    = (ram_rdata[SPAN_W-1:0] == '0) ? SPAN_W'(1) : ram_rdata[SPAN_W-1:0];
	assign t_bytes   = 17'(t_span) << 4;
	assign fit       = (t_kind == KIND_FREE) && ({1'b0, t_bytes} >= need_q);
	assign rem       = t_bytes - need_q[16:0];
	assign split     = rem >= 17'(FREE_HDR_BYTES);
	assign need_span = need_q[SPAN_W+3:4];
	assign nxt       = tgt_q + t_span;
	assign tspan_bytes = 17'(span_q) << 4;

	assign cmd_adj  = (17'(cmd.request_bytes) + 17'(GRANULE_BYTES - 1)) & ~17'(GRANULE_BYTES - 1);
	assign bad_free = (cmd.block_addr < 16'(USED_HDR_BYTES)) || (cmd.block_addr[3:0] != 4'd0)
		|| (18'((cmd.block_addr - 16'(USED_HDR_BYTES)) >> 4) >= 18'(NGRAN));

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, tag memory access and statistics commit.
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = g_q[GRAN_AW-1:0];
		ram_wdata = '0;
		ram_raddr = g_q[GRAN_AW-1:0];
		upd.we    = 1'b0;
		upd.val   = st;
		unique case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = {KIND_FREE, 1'b0, SPAN_W'(NGRAN)};
				state_d   = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					if (cmd.op == OP_ALLOC) begin
						state_d = S_CHK;
					end else if (bad_free) begin
						state_d = S_DONE;
					end else begin
						state_d = S_FRD;
					end
				end
			end
			S_CHK: begin
				if (st.free_total < 17'(MIN_FREE_BYTES) || adj_q > st.free_total) begin
					state_d = S_DONE;
				end else begin
					state_d = S_ARD;
				end
			end
			S_ARD: begin
				state_d = (g_q >= SPAN_W'(NGRAN)) ? S_DONE : S_AEV;
			end
			S_AEV: begin
				if (fit) begin
					if (split) begin
						ram_we    = 1'b1;
						ram_waddr = GRAN_AW'(g_q + need_span);
						ram_wdata = {KIND_FREE, 1'b0, t_span - need_span};
					end
					state_d = S_AW2;
				end else begin
					state_d = S_ARD;
				end
			end
			S_AW2: begin
				ram_we     = 1'b1;
				ram_wdata  = {KIND_USED, 1'b0, uspan_q};
				upd.we     = 1'b1;
				upd.val.free_total = split_q ? st.free_total - need_q[16:0]
					: st.free_total - tspan_bytes + 17'(FREE_HDR_BYTES);
				upd.val.used_total = st.used_total + (17'(uspan_q) << 4)
					- 17'(USED_HDR_BYTES);
				upd.val.free_count = split_q ? st.free_count : st.free_count - 13'd1;
				upd.val.used_count = st.used_count + 13'd1;
				state_d    = S_DONE;
			end
			S_FRD: begin
				if (g_q < tgt_q && g_q < SPAN_W'(NGRAN)) begin
					state_d = S_FEV;
				end else if (g_q != tgt_q) begin
					state_d = S_DONE;
				end else begin
					state_d = S_FTGT;
				end
			end
			S_FEV: begin
				state_d = S_FRD;
			end
			S_FTGT: begin
				ram_raddr = nxt[GRAN_AW-1:0];
				if (t_kind != KIND_USED) begin
					state_d = S_DONE;
				end else if (nxt < SPAN_W'(NGRAN)) begin
					state_d = S_FNXT;
				end else begin
					state_d = S_FCOMMIT;
				end
			end
			S_FNXT: begin
				state_d = S_FCOMMIT;
			end
			S_FCOMMIT: begin
				ram_we = 1'b1;
				if (prev_free_q) begin
					ram_waddr = prev_q[GRAN_AW-1:0];
					ram_wdata = {KIND_FREE, 1'b0,
						prev_span_q + span_q + (nfree_q ? nspan_q : '0)};
				end else begin
					ram_waddr = tgt_q[GRAN_AW-1:0];
					ram_wdata = {KIND_FREE, 1'b0, span_q + (nfree_q ? nspan_q : '0)};
				end
				upd.we = 1'b1;
				upd.val.free_total = st.free_total + tspan_bytes - 17'(FREE_HDR_BYTES)
					+ (nfree_q ? 17'(FREE_HDR_BYTES) : '0)
					+ (prev_free_q ? 17'(FREE_HDR_BYTES) : '0);
				upd.val.used_total = st.used_total - tspan_bytes + 17'(USED_HDR_BYTES);
				upd.val.free_count = st.free_count + 13'd1 - 13'(nfree_q)
					- 13'(prev_free_q);
				upd.val.used_count = st.used_count - 13'd1;
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Working registers of the walk.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q        <= cmd.op;
				adj_q       <= cmd_adj;
				need_q      <= 18'(cmd_adj) + 18'(USED_HDR_BYTES);
				g_q         <= '0;
				tgt_q       <= SPAN_W'((cmd.block_addr - 16'(USED_HDR_BYTES)) >> 4);
				has_prev_q  <= 1'b0;
				prev_free_q <= 1'b0;
				prev_q      <= '0;
				prev_span_q <= '0;
				addr_q      <= '0;
				status_q    <= (cmd.op == OP_FREE && bad_free) ? ST_BAD_ADDR : ST_OK;
			end
			S_CHK: begin
				if (st.free_total < 17'(MIN_FREE_BYTES) || adj_q > st.free_total) begin
					status_q <= ST_NO_MEM;
				end
			end
			S_ARD: begin
				if (g_q >= SPAN_W'(NGRAN)) begin
					status_q <= ST_NO_MEM;
				end
			end
			S_AEV: begin
				if (fit) begin
					split_q <= split;
					span_q  <= t_span;
					uspan_q <= split ? need_span : t_span;
					addr_q  <= 16'((32'(g_q) << 4) + 32'(USED_HDR_BYTES));
				end else begin
					g_q <= g_q + t_span;
				end
			end
			S_FRD: begin
				if (!(g_q < tgt_q && g_q < SPAN_W'(NGRAN)) && g_q != tgt_q) begin
					status_q <= ST_BAD_ADDR;
				end
			end
			S_FEV: begin
				prev_q      <= g_q;
				has_prev_q  <= 1'b1;
				prev_free_q <= (t_kind == KIND_FREE);
				prev_span_q <= t_span;
				g_q         <= g_q + t_span;
			end
			S_FTGT: begin
				span_q  <= t_span;
				nfree_q <= 1'b0;
				if (t_kind != KIND_USED) begin
					status_q <= ST_BAD_ADDR;
				end
			end
			S_FNXT: begin
				nfree_q <= (t_kind == KIND_FREE);
				nspan_q <= t_span;
			end
			default: begin
			end
		endcase
	end

	assign busy       = (state_q != S_IDLE);
	assign fin        = (state_q == S_DONE);
	assign fin_status = status_q;
	assign fin_addr   = (op_q == OP_ALLOC && status_q == ST_OK) ? addr_q : '0;

	// A previous-block merge is only possible once the walk has passed a block.
	a_prev_seen: assert property (@(posedge clk) disable iff (!arst_n)
		prev_free_q |-> has_prev_q) else $error("merge below without a walked block");
	// Statistics are committed only just before the result.
	a_commit_done: assert property (@(posedge clk) disable iff (!arst_n)
		upd.we |=> fin) else $error("statistics commit not followed by result");
	// A free never reports a data address.
	a_free_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && op_q == OP_FREE) |-> fin_addr == '0) else $error("free with address");

endmodule

@@ hdl/first_fit_heap_allocator.sv @@
// Channel  | Ports                 | Handshake
// command  | start, busy, cmd      | taken when start is high and busy is low
// result   | done, result          | one cycle strobe, cannot be held off
//
// An allocate checks the free total, then walks the block tags from address zero,
// reading each block visited through the single read port of the tag memory, then
// commits, finishes and registers the result; one refused for low memory skips the walk.
// A free walks up to the named block the same way, then reads it and its upper
// neighbor; a malformed address goes straight to the result.
// After reset the block writes the initial heap tag with busy high.
// The result is registered, and the receiver cannot stall the block.
module first_fit_heap_allocator import ffha_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

	stats_t             st;
	stats_upd_t         upd;
	logic [16:0]        peak_bytes;
	logic [12:0]        peak_blocks;
	logic               fin;
	logic [1:0]         fin_status;
	logic [15:0]        fin_addr;
	logic               ram_we;
	logic [GRAN_AW-1:0] ram_waddr, ram_raddr;
	logic [TAG_W-1:0]   ram_wdata, ram_rdata;
	logic               done_q;
	result_t            result_q;

	ffha_ram #(.WIDTH(TAG_W), .DEPTH(NGRAN)) u_tags (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	ffha_stats u_stats (
		.clk(clk), .arst_n(arst_n), .upd(upd), .cur(st),
		.peak_bytes(peak_bytes), .peak_blocks(peak_blocks)
	);

	ffha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy),
		.fin(fin), .fin_status(fin_status), .fin_addr(fin_addr),
		.st(st), .upd(upd),
		.ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr), .ram_rdata(ram_rdata)
	);

	// Result register, loaded after the statistics have settled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			result_q.status      <= fin_status;
			result_q.data_addr   <= fin_addr;
			result_q.free_bytes  <= st.free_total;
			result_q.used_bytes  <= st.used_total;
			result_q.free_blocks <= st.free_count;
			result_q.used_blocks <= st.used_count;
			result_q.peak_bytes  <= peak_bytes;
			result_q.peak_blocks <= peak_blocks;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// Results come singly, after work that kept the block busy.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back to back result strobes");
	a_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without work");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == ST_OK || result.status == ST_NO_MEM
		|| result.status == ST_BAD_ADDR)) else $error("undefined status");

endmodule

@@ bench/tb_first_fit_heap_allocator.sv @@
module tb_first_fit_heap_allocator;
	import ffha_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KF = 1;
	localparam int KU = 2;

	// Expected heap behavior and the queue of results still owed.
	class heap_scoreboard;
		int kind[NGRAN];
		int span[NGRAN];
		int free_total, used_total, free_cnt, used_cnt, peak_total, peak_cnt;
		result_t pending[$];
		int mismatches;
		int stray;

		function void clear();
			for (int i = 0; i < NGRAN; i++) begin
				kind[i] = 0;
				span[i] = 0;
			end
			kind[0] = KF;
			span[0] = NGRAN;
			free_total = HEAP_BYTES - FREE_HDR_BYTES;
			used_total = 0;
			free_cnt = 1;
			used_cnt = 0;
			peak_total = 0;
			peak_cnt = 0;
			mismatches = 0;
			stray = 0;
		endfunction

		function void bump_peaks();
			if (used_total > peak_total) peak_total = used_total;
			if (used_cnt > peak_cnt) peak_cnt = used_cnt;
		endfunction

		function logic [1:0] allocate(int req, output int addr);
			int adj, need, g, b, rem, us;
			adj = (req + 15) & ~15;
			need = adj + USED_HDR_BYTES;
			addr = 0;
			if (free_total < MIN_FREE_BYTES || adj > free_total) return ST_NO_MEM;
			g = 0;
			while (g < NGRAN) begin
				b = span[g] * GRANULE_BYTES;
				if (kind[g] == KF && b >= need) begin
					rem = b - need;
					us = span[g];
					free_total -= b - FREE_HDR_BYTES;
					if (rem >= FREE_HDR_BYTES) begin
						us = need / GRANULE_BYTES;
						if (g + us < NGRAN) begin
							kind[g + us] = KF;
							span[g + us] = span[g] - us;
						end
						free_total += rem - FREE_HDR_BYTES;
						free_cnt++;
					end
					kind[g] = KU;
					span[g] = us;
					used_total += us * GRANULE_BYTES - USED_HDR_BYTES;
					used_cnt++;
					free_cnt--;
					bump_peaks();
					addr = g * GRANULE_BYTES + USED_HDR_BYTES;
					return ST_OK;
				end
				g += (span[g] == 0) ? 1 : span[g];
			end
			return ST_NO_MEM;
		endfunction

		function logic [1:0] release_block(int addr);
			int tgt, g, prev, s, nxt;
			bit has_prev;
			if (addr < USED_HDR_BYTES) return ST_BAD_ADDR;
			if ((addr - USED_HDR_BYTES) % GRANULE_BYTES != 0) return ST_BAD_ADDR;
			tgt = (addr - USED_HDR_BYTES) / GRANULE_BYTES;
			if (tgt >= NGRAN) return ST_BAD_ADDR;
			g = 0;
			prev = 0;
			has_prev = 0;
			while (g < NGRAN && g < tgt) begin
				prev = g;
				has_prev = 1;
				g += (span[g] == 0) ? 1 : span[g];
			end
			if (g != tgt || kind[tgt] != KU) return ST_BAD_ADDR;
			s = span[tgt];
			free_total += s * GRANULE_BYTES - FREE_HDR_BYTES;
			used_total -= s * GRANULE_BYTES - USED_HDR_BYTES;
			kind[tgt] = KF;
			free_cnt++;
			used_cnt--;
			nxt = tgt + s;
			// Merge with the free block just above.
			if (nxt < NGRAN && kind[nxt] == KF) begin
				s += span[nxt];
				kind[nxt] = 0;
				span[nxt] = 0;
				span[tgt] = s;
				free_cnt--;
				free_total += FREE_HDR_BYTES;
			end
			// Merge with the free block just below.
			if (has_prev && kind[prev] == KF) begin
				span[prev] += s;
				kind[tgt] = 0;
				span[tgt] = 0;
				free_cnt--;
				free_total += FREE_HDR_BYTES;
			end
			bump_peaks();
			return ST_OK;
		endfunction

		function void note_command(cmd_t c, output int addr);
			result_t r;
			addr = 0;
			if (c.op == OP_ALLOC) r.status = allocate(int'(c.request_bytes), addr);
			else r.status = release_block(int'(c.block_addr));
			r.data_addr = addr[15:0];
			r.free_bytes = free_total[16:0];
			r.used_bytes = used_total[16:0];
			r.free_blocks = free_cnt[12:0];
			r.used_blocks = used_cnt[12:0];
			r.peak_bytes = peak_total[16:0];
			r.peak_blocks = peak_cnt[12:0];
			pending.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				stray++;
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	cmd_t cmd = '0;
	logic done;
	result_t result;

	heap_scoreboard sb;
	int live_addrs[$];
	bit sender_idles = 1;
	int n_alloc, n_free, n_fail;

	first_fit_heap_allocator DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .result(result)
	);

	always #2 clk = ~clk;

	// Collect results at each edge.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) sb.check_result(result);
	end

	// Drive one item and hold it until the block takes it.
	task automatic issue(input logic op, input int req, input int baddr);
		cmd_t c;
		int addr;
		c.op = op;
		c.request_bytes = req[15:0];
		c.block_addr = baddr[15:0];
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_command(c, addr);
		if (op == OP_ALLOC) begin
			n_alloc++;
			if (sb.pending[$].status == ST_OK) live_addrs.push_back(addr);
			else n_fail++;
		end else begin
			n_free++;
			if (sb.pending[$].status == ST_OK)
				foreach (live_addrs[i])
					if (live_addrs[i] == baddr) begin
						live_addrs.delete(i);
						break;
					end
		end
		// A random gap between items, sometimes none.
		if (sender_idles && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic free_random_live();
		int i;
		i = $urandom_range(0, live_addrs.size() - 1);
		issue(OP_FREE, 0, live_addrs[i]);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		#400ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int r;
		sb = new();
		sb.clear();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: edge sizes, bad frees, merges on both sides.
		issue(OP_ALLOC, 0, 0);
		issue(OP_ALLOC, 1, 0);
		issue(OP_ALLOC, 16, 0);
		issue(OP_ALLOC, 17, 0);
		issue(OP_ALLOC, 65535, 0);
		issue(OP_FREE, 0, 0);
		issue(OP_FREE, 0, 15);
		issue(OP_FREE, 0, 17);
		issue(OP_FREE, 0, 65535);
		issue(OP_FREE, 0, 65520);
		issue(OP_FREE, 0, 200);
		issue(OP_FREE, 0, 32);
		issue(OP_FREE, 0, 32);
		issue(OP_FREE, 0, 16);
		issue(OP_FREE, 0, 64);
		issue(OP_FREE, 0, 48);
		issue(OP_ALLOC, 65504, 0);
		issue(OP_ALLOC, 65488, 0);
		issue(OP_ALLOC, 0, 32767);
		issue(OP_FREE, 32768, 16);
		issue(OP_ALLOC, 65000, 0);
		issue(OP_ALLOC, 520, 0);
		issue(OP_ALLOC, 500, 0);
		issue(OP_FREE, 0, 16);
		drain();

		// Random traffic: mostly valid frees and modest allocations.
		for (int i = 0; i < 750; i++) begin
			if (i == 650) sender_idles = 0;
			if (i == 300) drain();
			r = $urandom_range(0, 99);
			if (r < 40 || (r < 55 && live_addrs.size() == 0)) begin
				if ($urandom_range(0, 19) == 0) issue(OP_ALLOC, $urandom, $urandom);
				else issue(OP_ALLOC, $urandom_range(0, 3000), $urandom);
			end else if (r < 85 && live_addrs.size() != 0) begin
				free_random_live();
			end else begin
				issue(OP_FREE, $urandom, $urandom);
			end
		end
		drain();

		$display("covered %0d allocates (%0d refused) and %0d frees, peak %0d bytes",
			n_alloc, n_fail, n_free, sb.peak_total);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
